// ----- rtl/cfd_pkg.sv -----
// Shared types and constants for the CRC-checked frame decoder.
// No dependencies; imported by cfd_crc and crc_checked_frame_decoder.
package cfd_pkg;

	localparam int BYTE_W      = 8;
	localparam int CRC_W       = 16;
	localparam int MAX_PAYLOAD = 64;
	localparam int IDX_W       = 6;
	localparam int LEN_W       = 7;

	localparam logic [CRC_W-1:0]  CRC_POLY       = 16'h1021;
	localparam logic [CRC_W-1:0]  CRC_INIT       = 16'hFFFF;
	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd126;

	// Commands to the bit-serial CRC unit
	typedef struct packed {
		logic start;   // crc <= init ^ (byte << 8)
		logic feed;    // crc <= crc ^ (byte << 8)
		logic step;    // one shift of the polynomial division
	} crc_ctl_t;

endpackage

// ----- rtl/cfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/cfd_crc.sv -----
// Bit-serial CRC-16/CCITT-FALSE unit: one polynomial shift per step command.
// Depends on cfd_pkg.
module cfd_crc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfd_pkg::crc_ctl_t             ctl,
	input  logic [cfd_pkg::BYTE_W-1:0]    data_byte,
	output logic [cfd_pkg::CRC_W-1:0]     crc
);

	import cfd_pkg::*;

	logic [CRC_W-1:0] crc_q;
	logic [CRC_W-1:0] byte_hi;
	logic [CRC_W-1:0] shifted;

	assign byte_hi = {data_byte, {(CRC_W-BYTE_W){1'b0}}};
	assign shifted = {crc_q[CRC_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.start) begin
			crc_q <= CRC_INIT ^ byte_hi;
		end else if (ctl.feed) begin
			crc_q <= crc_q ^ byte_hi;
		end else if (ctl.step) begin
			crc_q <= crc_q[CRC_W-1] ? (shifted ^ CRC_POLY) : shifted;
		end
	end

	assign crc = crc_q;

endmodule

// ----- rtl/crc_checked_frame_decoder.sv -----
// Length-prefixed frame decoder with CRC-16/CCITT-FALSE check.
// Depends on cfd_pkg, cfd_crc and cfd_ram.
//
// Input channel: rx_byte with in_valid/in_stall. Output channel: one result
// per payload byte, or one for an empty frame (frame_type, payload_len,
// has_payload, byte_index, payload_byte, last) with out_valid/out_stall.
// start_byte is to be written via cfg_wr_en/cfg_wr_data only while the block
// is idle; the user must keep to this, the block does not enforce it.
// A byte that enters the CRC (start, type, length, payload) stalls the input
// while the bit-serial CRC unit shifts it; bytes skipped while hunting and
// the two CRC bytes do not. After the second CRC byte of a good frame, each
// result is read from the payload RAM (SQ_RD), loaded (SQ_LD) and held until
// transferred (SQ_OUT); an empty frame's single result is loaded directly.
// in_stall stays high from the CRC byte until the last result is taken.
// Bad-CRC or oversized frames are read to the end and dropped.
// Reset returns to hunting for the start byte, start_byte to 126, and clears
// out_valid. A stalled output holds its result and the input stays stalled.
module crc_checked_frame_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [cfd_pkg::BYTE_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cfd_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cfd_pkg::BYTE_W-1:0]  frame_type,
	output logic [cfd_pkg::LEN_W-1:0]   payload_len,
	output logic                        has_payload,
	output logic [cfd_pkg::IDX_W-1:0]   byte_index,
	output logic [cfd_pkg::BYTE_W-1:0]  payload_byte,
	output logic                        last
);

	import cfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT, PH_TYPE, PH_LEN, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE, SQ_SHIFT, SQ_RD, SQ_LD, SQ_OUT
	} seq_t;

	phase_t              phase_q;
	seq_t                seq_q;
	logic [BYTE_W-1:0]   start_byte_q;
	logic [BYTE_W-1:0]   frame_kind_q;
	logic [BYTE_W-1:0]   frame_len_q;
	logic [BYTE_W-1:0]   bytes_seen_q;
	logic [BYTE_W-1:0]   crc_hi_q;
	logic [2:0]          bit_cnt_q;
	logic [IDX_W-1:0]    rd_idx_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   frame_type_q;
	logic [LEN_W-1:0]    payload_len_q;
	logic                has_payload_q;
	logic [IDX_W-1:0]    byte_index_q;
	logic [BYTE_W-1:0]   payload_byte_q;
	logic                last_q;

	logic                in_xfer;
	logic                out_xfer;
	crc_ctl_t            crc_ctl;
	logic [CRC_W-1:0]    crc_val;
	logic                ram_we;
	logic                ram_re;
	logic [BYTE_W-1:0]   ram_rdata;
	logic [BYTE_W-1:0]   seen_next;
	logic                crc_ok;
	logic [LEN_W-1:0]    rd_next;

	assign in_stall  = (seq_q != SQ_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign seen_next = bytes_seen_q + 8'd1;
	assign rd_next   = {1'b0, rd_idx_q} + 7'd1;
	assign ram_re    = (seq_q == SQ_RD);
	assign crc_ok    = ({crc_hi_q, rx_byte} == crc_val) &&
	                   (frame_len_q <= BYTE_W'(MAX_PAYLOAD));

	always_comb begin
		crc_ctl = '0;
		ram_we  = 1'b0;
		if (in_xfer) begin
			unique case (phase_q) inside
				PH_HUNT:    crc_ctl.start = (rx_byte == start_byte_q);
				PH_TYPE,
				PH_LEN:     crc_ctl.feed = 1'b1;
				PH_PAYLOAD: begin
					crc_ctl.feed = 1'b1;
					ram_we       = (bytes_seen_q < BYTE_W'(MAX_PAYLOAD));
				end
				default:    crc_ctl = '0;
			endcase
		end
		if (seq_q == SQ_SHIFT) begin
			crc_ctl.step = 1'b1;
		end
	end

	cfd_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (crc_ctl),
		.data_byte (rx_byte),
		.crc       (crc_val)
	);

	cfd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bytes_seen_q[IDX_W-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			seq_q          <= SQ_IDLE;
			start_byte_q   <= START_BYTE_RST;
			frame_kind_q   <= '0;
			frame_len_q    <= '0;
			bytes_seen_q   <= '0;
			crc_hi_q       <= '0;
			bit_cnt_q      <= '0;
			rd_idx_q       <= '0;
			out_valid_q    <= 1'b0;
			frame_type_q   <= '0;
			payload_len_q  <= '0;
			has_payload_q  <= 1'b0;
			byte_index_q   <= '0;
			payload_byte_q <= '0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				start_byte_q <= cfg_wr_data;
			end
			unique case (seq_q)
				SQ_IDLE: begin
					if (in_xfer) begin
						bit_cnt_q <= '0;
						unique case (phase_q)
							PH_HUNT: begin
								if (rx_byte == start_byte_q) begin
									phase_q <= PH_TYPE;
									seq_q   <= SQ_SHIFT;
								end
							end
							PH_TYPE: begin
								frame_kind_q <= rx_byte;
								phase_q      <= PH_LEN;
								seq_q        <= SQ_SHIFT;
							end
							PH_LEN: begin
								frame_len_q  <= rx_byte;
								bytes_seen_q <= '0;
								phase_q      <= (rx_byte == '0) ? PH_CRC_HI : PH_PAYLOAD;
								seq_q        <= SQ_SHIFT;
							end
							PH_PAYLOAD: begin
								bytes_seen_q <= seen_next;
								if (seen_next == frame_len_q) begin
									phase_q <= PH_CRC_HI;
								end
								seq_q <= SQ_SHIFT;
							end
							PH_CRC_HI: begin
								crc_hi_q <= rx_byte;
								phase_q  <= PH_CRC_LO;
							end
							PH_CRC_LO: begin
								phase_q <= PH_HUNT;
								if (crc_ok) begin
									if (frame_len_q == '0) begin
										// empty frame: single result, no RAM read
										frame_type_q   <= frame_kind_q;
										payload_len_q  <= '0;
										has_payload_q  <= 1'b0;
										byte_index_q   <= '0;
										payload_byte_q <= '0;
										last_q         <= 1'b1;
										out_valid_q    <= 1'b1;
										seq_q          <= SQ_OUT;
									end else begin
										rd_idx_q <= '0;
										seq_q    <= SQ_RD;
									end
								end
							end
							default: phase_q <= PH_HUNT;
						endcase
					end
				end
				SQ_SHIFT: begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == '1) begin
						seq_q <= SQ_IDLE;
					end
				end
				SQ_RD: seq_q <= SQ_LD;
				SQ_LD: begin
					frame_type_q   <= frame_kind_q;
					payload_len_q  <= frame_len_q[LEN_W-1:0];
					has_payload_q  <= 1'b1;
					byte_index_q   <= rd_idx_q;
					payload_byte_q <= ram_rdata;
					last_q         <= (rd_next == frame_len_q[LEN_W-1:0]);
					out_valid_q    <= 1'b1;
					seq_q          <= SQ_OUT;
				end
				SQ_OUT: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							seq_q <= SQ_IDLE;
						end else begin
							rd_idx_q <= rd_next[IDX_W-1:0];
							seq_q    <= SQ_RD;
						end
					end
				end
				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_type   = frame_type_q;
	assign payload_len  = payload_len_q;
	assign has_payload  = has_payload_q;
	assign byte_index   = byte_index_q;
	assign payload_byte = payload_byte_q;
	assign last         = last_q;

	// input is never open while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input open while a result is pending");

	a_release_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !in_stall)
		else $error("input not released after last result");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_payload |-> last && (payload_len == '0))
		else $error("empty-frame result malformed");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_payload |-> ({1'b0, byte_index} < payload_len))
		else $error("byte_index beyond payload length");

endmodule
